// ===== rtl/s20x_pkg.sv =====
// shared types, constants and functions for the salsa20 stream xor block
`timescale 1ns / 1ps
`default_nettype none
package s20x_pkg;

    localparam int ROUNDS = 20;
    localparam int RND_W = $clog2(ROUNDS + 1);

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;
    localparam logic [31:0] TAU_1   = 32'h3120646e;
    localparam logic [31:0] TAU_2   = 32'h79622d36;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_MODE = 3'd0;
    localparam logic [2:0] REG_KEY_0    = 3'd1;
    localparam logic [2:0] REG_KEY_1    = 3'd2;
    localparam logic [2:0] REG_KEY_2    = 3'd3;
    localparam logic [2:0] REG_KEY_3    = 3'd4;
    localparam logic [2:0] REG_NONCE    = 3'd5;
    localparam logic [2:0] REG_START    = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_STREAM
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // load initial state from config and counter
        logic round;      // run one column or row round
        logic finish;     // last round and feed-forward add into keystream block
        logic take;       // consume one byte
        logic new_msg;    // reload counter from start value
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_in_block;  // byte offset is 63
    } dp_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // quarter round on four words
    function automatic logic [127:0] quarter(input logic [127:0] q);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = q[31:0];
        b = q[63:32];
        c = q[95:64];
        d = q[127:96];
        b = b ^ rotl(a + d, 7);
        c = c ^ rotl(b + a, 9);
        d = d ^ rotl(c + b, 13);
        a = a ^ rotl(d + c, 18);
        quarter = {d, c, b, a};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/s20x_ctrl.sv =====
// controller state machine for the salsa20 stream xor block
`timescale 1ns / 1ps
`default_nettype none
module s20x_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    input  wire logic             out_free,
    input  wire s20x_pkg::dp_sts_t sts,
    output s20x_pkg::dp_cmd_t     cmd,
    output logic                  in_stall
);

    s20x_pkg::state_t state_reg, state_next;
    logic [s20x_pkg::RND_W-1:0] rnd_reg, rnd_next;
    logic in_msg_reg, in_msg_next;
    logic take;

    assign take = (state_reg == s20x_pkg::ST_STREAM) && in_valid && out_free;
    assign in_stall = !((state_reg == s20x_pkg::ST_STREAM) && out_free);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= s20x_pkg::ST_IDLE;
            rnd_reg    <= '0;
            in_msg_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rnd_reg    <= rnd_next;
            in_msg_reg <= in_msg_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        rnd_next    = rnd_reg;
        in_msg_next = in_msg_reg;
        case (state_reg)
            s20x_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = s20x_pkg::ST_ROUND;
                    rnd_next    = '0;
                    in_msg_next = 1'b1;
                end
            end
            s20x_pkg::ST_ROUND:
            begin
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == s20x_pkg::RND_W'(s20x_pkg::ROUNDS - 1))
                    state_next = s20x_pkg::ST_FINAL;
            end
            s20x_pkg::ST_FINAL:
                state_next = s20x_pkg::ST_STREAM;
            s20x_pkg::ST_STREAM:
            begin
                if (take)
                begin
                    if (in_last)
                    begin
                        state_next  = s20x_pkg::ST_IDLE;
                        in_msg_next = 1'b0;
                    end
                    else if (sts.last_in_block)
                    begin
                        state_next = s20x_pkg::ST_ROUND;
                        rnd_next   = '0;
                    end
                end
            end
            default: state_next = s20x_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            s20x_pkg::ST_IDLE:
            begin
                cmd.new_msg = in_valid && !in_msg_reg;
            end
            s20x_pkg::ST_ROUND:
            begin
                cmd.load  = (rnd_reg == '0);
                cmd.round = (rnd_reg != '0);
            end
            s20x_pkg::ST_FINAL:
                cmd.finish = 1'b1;
            s20x_pkg::ST_STREAM:
                cmd.take = take;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/s20x_dp.sv =====
// datapath: config registers, salsa20 round unit, keystream and output register
`timescale 1ns / 1ps
`default_nettype none
module s20x_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,
    input  wire s20x_pkg::dp_cmd_t cmd,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic              out_stall,
    output s20x_pkg::dp_sts_t      sts,
    output logic                   out_free,
    output logic                   out_valid,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    logic        mode_reg;
    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg;
    logic [63:0] start_reg;
    logic [63:0] count_reg;
    logic [5:0]  off_reg;
    logic [31:0] init_reg [16];
    logic [31:0] work_reg [16];
    logic [511:0] ks_reg;
    logic        ov_reg;
    logic [7:0]  ob_reg;
    logic        ol_reg;
    logic        odd_reg;
    logic [31:0] init_w [16];
    logic [31:0] rnd_w [16];
    logic [127:0] q0, q1, q2, q3;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b1;
            key_reg   <= '{default: '0};
            nonce_reg <= '0;
            start_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                s20x_pkg::REG_KEY_MODE: mode_reg   <= cfg_data[0];
                s20x_pkg::REG_KEY_0:    key_reg[0] <= cfg_data;
                s20x_pkg::REG_KEY_1:    key_reg[1] <= cfg_data;
                s20x_pkg::REG_KEY_2:    key_reg[2] <= cfg_data;
                s20x_pkg::REG_KEY_3:    key_reg[3] <= cfg_data;
                s20x_pkg::REG_NONCE:    nonce_reg  <= cfg_data;
                s20x_pkg::REG_START:    start_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // initial state words
    always_comb
    begin
        logic [63:0] h0;
        logic [63:0] h1;
        h0 = mode_reg ? key_reg[2] : key_reg[0];
        h1 = mode_reg ? key_reg[3] : key_reg[1];
        init_w[0]  = s20x_pkg::SIGMA_0;
        init_w[1]  = key_reg[0][31:0];
        init_w[2]  = key_reg[0][63:32];
        init_w[3]  = key_reg[1][31:0];
        init_w[4]  = key_reg[1][63:32];
        init_w[5]  = mode_reg ? s20x_pkg::SIGMA_1 : s20x_pkg::TAU_1;
        init_w[6]  = nonce_reg[31:0];
        init_w[7]  = nonce_reg[63:32];
        init_w[8]  = count_reg[31:0];
        init_w[9]  = count_reg[63:32];
        init_w[10] = mode_reg ? s20x_pkg::SIGMA_2 : s20x_pkg::TAU_2;
        init_w[11] = h0[31:0];
        init_w[12] = h0[63:32];
        init_w[13] = h1[31:0];
        init_w[14] = h1[63:32];
        init_w[15] = s20x_pkg::SIGMA_3;
    end

    // one round: column round when even, row round when odd
    always_comb
    begin
        rnd_w = work_reg;
        if (!odd_reg)
        begin
            q0 = s20x_pkg::quarter({work_reg[12], work_reg[8], work_reg[4], work_reg[0]});
            q1 = s20x_pkg::quarter({work_reg[1], work_reg[13], work_reg[9], work_reg[5]});
            q2 = s20x_pkg::quarter({work_reg[6], work_reg[2], work_reg[14], work_reg[10]});
            q3 = s20x_pkg::quarter({work_reg[11], work_reg[7], work_reg[3], work_reg[15]});
            {rnd_w[12], rnd_w[8], rnd_w[4], rnd_w[0]}   = q0;
            {rnd_w[1], rnd_w[13], rnd_w[9], rnd_w[5]}   = q1;
            {rnd_w[6], rnd_w[2], rnd_w[14], rnd_w[10]}  = q2;
            {rnd_w[11], rnd_w[7], rnd_w[3], rnd_w[15]}  = q3;
        end
        else
        begin
            q0 = s20x_pkg::quarter({work_reg[3], work_reg[2], work_reg[1], work_reg[0]});
            q1 = s20x_pkg::quarter({work_reg[4], work_reg[7], work_reg[6], work_reg[5]});
            q2 = s20x_pkg::quarter({work_reg[9], work_reg[8], work_reg[11], work_reg[10]});
            q3 = s20x_pkg::quarter({work_reg[14], work_reg[13], work_reg[12], work_reg[15]});
            {rnd_w[3], rnd_w[2], rnd_w[1], rnd_w[0]}    = q0;
            {rnd_w[4], rnd_w[7], rnd_w[6], rnd_w[5]}    = q1;
            {rnd_w[9], rnd_w[8], rnd_w[11], rnd_w[10]}  = q2;
            {rnd_w[14], rnd_w[13], rnd_w[12], rnd_w[15]} = q3;
        end
    end

    // round state and keystream block
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            init_reg <= init_w;
            work_reg <= init_w;
            odd_reg  <= 1'b0;
        end
        else if (cmd.round)
        begin
            work_reg <= rnd_w;
            odd_reg  <= !odd_reg;
        end
        else if (cmd.finish)
        begin
            work_reg <= rnd_w;
            for (int k = 0; k < 16; k++)
                ks_reg[32*k +: 32] <= rnd_w[k] + init_reg[k];
        end
    end

    // counter and byte offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            off_reg   <= '0;
        end
        else if (cmd.new_msg)
        begin
            count_reg <= start_reg;
            off_reg   <= '0;
        end
        else if (cmd.take)
        begin
            off_reg <= off_reg + 6'd1;
            if (off_reg == 6'd63)
                count_reg <= count_reg + 64'd1;
            if (last_byte)
                off_reg <= '0;
        end
    end

    assign sts.last_in_block = (off_reg == 6'd63);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.take)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ob_reg <= data_byte ^ ks_reg[{off_reg, 3'b000} +: 8];
            ol_reg <= last_byte;
        end
    end

    assign out_free  = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;

endmodule
`default_nettype wire

// ===== rtl/salsa20_stream_xor_top.sv =====
// top level of the salsa20 stream xor block
//  channel | direction | handshake           | payload
//  input   | in        | in_valid/in_stall   | data_byte, last_byte
//  output  | out       | out_valid/out_stall | out_byte, out_last
//  config  | in        | cfg_we              | cfg_index, cfg_data
// each 64-byte block stalls the input in the round unit (load, 19 rounds, then the
// 20th round with the feed-forward add), then one byte per cycle while the output
// is free; a message start first passes through idle, where the input also stalls.
// reset clears control state and sets all config registers to their defaults.
// a stalled output holds its byte; input is stalled while a block is computed and
// while the output register is full and its receiver stalls.
`timescale 1ns / 1ps
`default_nettype none
module salsa20_stream_xor_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    s20x_pkg::dp_cmd_t cmd;
    s20x_pkg::dp_sts_t sts;
    logic out_free;

    s20x_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(last_byte),
        .out_free(out_free), .sts(sts), .cmd(cmd), .in_stall(in_stall)
    );

    s20x_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .data_byte(data_byte),
        .last_byte(last_byte), .out_stall(out_stall), .sts(sts),
        .out_free(out_free), .out_valid(out_valid), .out_byte(out_byte),
        .out_last(out_last)
    );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the salsa20 stream xor block
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        out_last;

    salsa20_stream_xor_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .out_last(out_last)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
    } cipher_out_t;

    // shadow of the configuration registers
    logic        mdl_key_mode;
    logic [63:0] mdl_key [4];
    logic [63:0] mdl_nonce;
    logic [63:0] mdl_start;
    // shadow of the keystream state
    logic [31:0] mdl_block [16];
    logic [63:0] mdl_count;
    logic [5:0]  mdl_offset;
    logic        mdl_in_msg;

    cipher_out_t expected_q[$];
    int          mismatches;
    int          n_sent;
    int          n_recv;
    int          n_msgs;
    bit          hold_recv;
    bit          gaps_on;

    function automatic logic [31:0] rot32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // compute one keystream block from the shadow state
    task automatic gen_keystream_block();
        logic [31:0] init [16];
        logic [31:0] w [16];
        logic [31:0] c0, c1, c2, c3;
        logic [63:0] hi0, hi1;
        int qi [4];
        int r, k;
        c0 = 32'h61707865;
        c3 = 32'h6b206574;
        c1 = mdl_key_mode ? 32'h3320646e : 32'h3120646e;
        c2 = mdl_key_mode ? 32'h79622d32 : 32'h79622d36;
        hi0 = mdl_key_mode ? mdl_key[2] : mdl_key[0];
        hi1 = mdl_key_mode ? mdl_key[3] : mdl_key[1];
        init[0] = c0; init[5] = c1; init[10] = c2; init[15] = c3;
        init[1] = mdl_key[0][31:0];  init[2] = mdl_key[0][63:32];
        init[3] = mdl_key[1][31:0];  init[4] = mdl_key[1][63:32];
        init[6] = mdl_nonce[31:0];   init[7] = mdl_nonce[63:32];
        init[8] = mdl_count[31:0];   init[9] = mdl_count[63:32];
        init[11] = hi0[31:0]; init[12] = hi0[63:32];
        init[13] = hi1[31:0]; init[14] = hi1[63:32];
        w = init;
        for (r = 0; r < s20x_pkg::ROUNDS; r++)
        begin
            for (k = 0; k < 4; k++)
            begin
                // column rounds on even passes, row rounds on odd
                if (r % 2 == 0)
                    qi = '{(5 * k) % 16, (5 * k + 4) % 16, (5 * k + 8) % 16,
                           (5 * k + 12) % 16};
                else
                    qi = '{5 * k, 4 * k + (k + 1) % 4, 4 * k + (k + 2) % 4,
                           4 * k + (k + 3) % 4};
                w[qi[1]] = w[qi[1]] ^ rot32(w[qi[0]] + w[qi[3]], 7);
                w[qi[2]] = w[qi[2]] ^ rot32(w[qi[1]] + w[qi[0]], 9);
                w[qi[3]] = w[qi[3]] ^ rot32(w[qi[2]] + w[qi[1]], 13);
                w[qi[0]] = w[qi[0]] ^ rot32(w[qi[3]] + w[qi[2]], 18);
            end
        end
        for (k = 0; k < 16; k++)
            mdl_block[k] = w[k] + init[k];
    endtask

    // predict the output for one accepted input byte
    task automatic predict_cipher_byte(input logic [7:0] d, input logic l);
        logic [31:0] word;
        cipher_out_t e;
        if (!mdl_in_msg)
        begin
            mdl_count  = mdl_start;
            mdl_offset = '0;
            mdl_in_msg = 1'b1;
        end
        if (mdl_offset == 0)
            gen_keystream_block();
        word = mdl_block[mdl_offset[5:2]];
        e.byte_val = d ^ word[mdl_offset[1:0] * 8 +: 8];
        e.last = l;
        expected_q.push_back(e);
        mdl_offset = mdl_offset + 6'd1;
        if (mdl_offset == 0)
            mdl_count = mdl_count + 64'd1;
        if (l)
        begin
            mdl_offset = '0;
            mdl_count  = mdl_start;
            mdl_in_msg = 1'b0;
            n_msgs++;
        end
    endtask

    task automatic reset_model();
        mdl_key_mode = 1'b1;
        for (int i = 0; i < 4; i++)
            mdl_key[i] = '0;
        mdl_nonce  = '0;
        mdl_start  = '0;
        mdl_count  = '0;
        mdl_offset = '0;
        mdl_in_msg = 1'b0;
    endtask

    // register write, block idle
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            s20x_pkg::REG_KEY_MODE: mdl_key_mode = val[0];
            s20x_pkg::REG_KEY_0:    mdl_key[0] = val;
            s20x_pkg::REG_KEY_1:    mdl_key[1] = val;
            s20x_pkg::REG_KEY_2:    mdl_key[2] = val;
            s20x_pkg::REG_KEY_3:    mdl_key[3] = val;
            s20x_pkg::REG_NONCE:    mdl_nonce = val;
            s20x_pkg::REG_START:    mdl_start = val;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // send one byte, holding it until accepted
    task automatic send_byte(input logic [7:0] d, input logic l);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = d;
        last_byte = l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_cipher_byte(d, l);
        n_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom), i == len - 1);
    endtask

    // output checker
    always @(posedge clk)
    begin
        cipher_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_recv++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: byte %h last %b", out_byte, out_last);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.byte_val !== out_byte || e.last !== out_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp byte %h last %b, got byte %h last %b",
                                 e.byte_val, e.last, out_byte, out_last);
                end
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        int len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_recv)
            begin
                out_stall <= 1'b1;
                repeat (200) @(negedge clk);
                out_stall <= 1'b0;
                hold_recv = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (len) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // directed stimulus: data and last flag, checked by the predictor
    typedef struct {
        logic [7:0] d;
        logic       l;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{8'h00, 1'b0},
        '{8'hff, 1'b0},
        '{8'h55, 1'b0},
        '{8'haa, 1'b1},
        '{8'h00, 1'b1},
        '{8'h01, 1'b0},
        '{8'h80, 1'b1}
    };

    // timeout
    initial
    begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        int msg_len;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; data_byte = '0; last_byte = 1'b0;
        mismatches = 0; n_sent = 0; n_recv = 0; n_msgs = 0;
        hold_recv = 1'b0; gaps_on = 1'b0;
        reset_model();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults after reset, then all-ones key and nonce
        foreach (dir_rows[i])
            send_byte(dir_rows[i].d, dir_rows[i].l);
        wait_drained();
        write_reg(s20x_pkg::REG_KEY_MODE, 64'd0);
        for (int r = s20x_pkg::REG_KEY_0; r <= s20x_pkg::REG_START; r++)
            write_reg(3'(r), '1);
        write_reg(3'd7, 64'h1234);
        // counter wrap across a block boundary
        send_message(70);
        wait_drained();
        write_reg(s20x_pkg::REG_KEY_MODE, 64'd1);
        write_reg(s20x_pkg::REG_START, 64'hffff_ffff_ffff_ffff);
        send_message(65);
        wait_drained();

        // random messages over several settings
        gaps_on = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_reg(s20x_pkg::REG_KEY_MODE, 64'($urandom_range(0, 1)));
            for (int r = s20x_pkg::REG_KEY_0; r <= s20x_pkg::REG_NONCE; r++)
                write_reg(3'(r), rand64());
            write_reg(s20x_pkg::REG_START,
                      ($urandom_range(0, 2) == 0) ? 64'hffff_ffff_ffff_fffe : rand64());
            if (ph == 2)
                hold_recv = 1'b1;
            for (int m = 0; m < 5; m++)
            begin
                msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 140)
                                                      : $urandom_range(1, 40);
                send_message(msg_len);
            end
            if (ph == 4)
                wait_drained();
        end
        while (n_sent < 1750)
            send_message($urandom_range(1, 90));

        wait_drained();
        $display("covered %0d bytes in %0d messages, both key sizes, counter wrap,",
                 n_sent, n_msgs);
        $display("random stalls on both sides and one long output hold");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/s20x_pkg.sv
rtl/s20x_ctrl.sv
rtl/s20x_dp.sv
rtl/salsa20_stream_xor_top.sv
test/tb_top.sv
